[design/spl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority list package
// Shared types and codes for the sorted priority list cells and top level.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;

    // Request codes on req_type.
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_DROP_HEAD  = 2'd1;
    localparam logic [1:0] REQ_INSERT     = 2'd2;
    localparam logic [1:0] REQ_REMOVE     = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // Operation broadcast to every cell.
    localparam logic [2:0] OP_IDLE         = 3'd0;
    localparam logic [2:0] OP_GROW_FRONT   = 3'd1;
    localparam logic [2:0] OP_GROW_SORTED  = 3'd2;
    localparam logic [2:0] OP_SHRINK_FRONT = 3'd3;
    localparam logic [2:0] OP_SHRINK_TAG   = 3'd4;

    localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};
    localparam logic signed [PRIO_W-1:0] DEFAULT_PRIO_RESET = 16'sd1000;

    typedef struct packed {
        logic                     valid;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [2:0]               op;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

[design/spl_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority list cell
// Holds one entry and shifts it toward the tail or the head as requested.
// ----------------------------------------------------------------------------
module spl_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  spl_pkg::cmd_t   cmd,
    input  spl_pkg::entry_t left_entry,
    input  logic           left_hit,
    input  logic           left_found,
    input  spl_pkg::entry_t right_entry,
    output spl_pkg::entry_t entry,
    output logic           hit,
    output logic           found
);
    import spl_pkg::*;

    logic                     valid_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    entry_t                   cur_entry;
    entry_t                   entry_next;
    logic                     match;

    assign cur_entry = {valid_reg, tag_reg, prio_reg};

    // The insertion point is the first cell that is empty or holds a priority
    // not below the new one; the list order makes these cells a suffix.
    always_comb
    begin
        case (cmd.op)
            OP_GROW_FRONT:  hit = 1'b1;
            OP_GROW_SORTED: hit = !cur_entry.valid || (cmd.prio <= cur_entry.prio);
            default:        hit = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_SHRINK_FRONT: match = cur_entry.valid;
            OP_SHRINK_TAG:   match = cur_entry.valid && (cur_entry.tag == cmd.tag);
            default:         match = 1'b0;
        endcase
    end

    assign found = left_found || match;

    always_comb
    begin
        entry_next = cur_entry;
        case (cmd.op)
            OP_GROW_FRONT, OP_GROW_SORTED:
            begin
                if (left_hit)
                begin
                    entry_next = left_entry;
                end
                else if (hit)
                begin
                    entry_next.valid = 1'b1;
                    entry_next.tag   = cmd.tag;
                    entry_next.prio  = cmd.prio;
                end
            end
            OP_SHRINK_FRONT, OP_SHRINK_TAG:
            begin
                if (found)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = cur_entry;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= entry_next.tag;
        prio_reg <= entry_next.prio;
    end

    assign entry = cur_entry;

endmodule

[design/sorted_priority_list.sv]
// ----------------------------------------------------------------------------
// Sorted priority list
// A list of tagged entries kept in ascending priority order in a chain of cells.
// ----------------------------------------------------------------------------
// The result of an item is strobed by done in the cycle after the item is
// accepted. Throughput: one item per cycle; busy is always low, because
// every cell compares and shifts in parallel within the cycle of acceptance.
// The receiver cannot stall, so no result is ever held back.
// Reset empties the list, clears the result strobe and loads the default
// priority register with 1000.
module sorted_priority_list #(
    parameter int CAPACITY  = 16,
    parameter int TAG_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic signed [spl_pkg::PRIO_W-1:0]   cfg_wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [spl_pkg::TAG_W-1:0]           name_tag,
    input  logic signed [spl_pkg::PRIO_W-1:0]   priority_req,
    output logic                                done,
    output logic [1:0]                          status,
    output logic                                head_valid,
    output logic [spl_pkg::TAG_W-1:0]           head_tag,
    output logic signed [spl_pkg::PRIO_W-1:0]   head_priority,
    output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);
    import spl_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // Only the low TAG_WIDTH bits of a tag are stored and compared.
    localparam int KEEP_W = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
    localparam logic [TAG_W-1:0] TAG_MASK = {TAG_W{1'b1}} >> (TAG_W - KEEP_W);

    logic signed [PRIO_W-1:0] default_prio_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;

    cmd_t   cmd;
    entry_t cell_entry [CAPACITY];
    logic   cell_hit   [CAPACITY];
    logic   cell_found [CAPACITY];

    logic accept;
    logic list_full;
    logic list_empty;
    logic signed [PRIO_W-1:0] front_prio;

    // The list is held in order from cell 0, so the last cell tells whether
    // the list is full and cell 0 whether it is empty.
    assign accept     = start && !busy;
    assign list_full  = cell_entry[CAPACITY-1].valid;
    assign list_empty = !cell_entry[0].valid;
    assign busy       = 1'b0;

    // A push at the front takes one below the head's priority, saturating at
    // the lowest value, or the configured default when the list is empty.
    always_comb
    begin
        if (list_empty)
        begin
            front_prio = default_prio_reg;
        end
        else if (cell_entry[0].prio == PRIO_MIN)
        begin
            front_prio = PRIO_MIN;
        end
        else
        begin
            front_prio = cell_entry[0].prio - PRIO_W'(1);
        end
    end

    // Decode the request into the operation broadcast along the chain. A grow
    // refused on a full list turns into an idle operation so that no cell moves.
    always_comb
    begin
        cmd.op   = OP_IDLE;
        cmd.tag  = name_tag & TAG_MASK;
        cmd.prio = priority_req;
        if (accept)
        begin
            case (req_type)
                REQ_PUSH_FRONT:
                begin
                    cmd.prio = front_prio;
                    if (!list_full)
                    begin
                        cmd.op = OP_GROW_FRONT;
                    end
                end
                REQ_INSERT:
                begin
                    if (!list_full)
                    begin
                        cmd.op = OP_GROW_SORTED;
                    end
                end
                REQ_DROP_HEAD:
                begin
                    cmd.op = OP_SHRINK_FRONT;
                end
                REQ_REMOVE:
                begin
                    cmd.op = OP_SHRINK_TAG;
                end
                default:
                begin
                    cmd.op = OP_IDLE;
                end
            endcase
        end
    end

    // The chain of cells. Each cell sees its left neighbor's entry and
    // insertion flag, the found flag rippling from the head, and its right
    // neighbor's entry. The ends are fed with an empty entry.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_h;
            logic   left_f;

            if (gi == 0)
            begin : g_head
                assign left_e = '0;
                assign left_h = 1'b0;
                assign left_f = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_h = cell_hit[gi-1];
                assign left_f = cell_found[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            spl_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .left_entry  (left_e),
                .left_hit    (left_h),
                .left_found  (left_f),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .hit         (cell_hit[gi]),
                .found       (cell_found[gi])
            );
        end
    endgenerate

    // Status and count follow the same decisions that move the cells.
    always_comb
    begin
        status_next = ST_DONE;
        count_next  = count_reg;
        case (req_type)
            REQ_PUSH_FRONT, REQ_INSERT:
            begin
                if (list_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_DROP_HEAD:
            begin
                if (list_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            REQ_REMOVE:
            begin
                if (!cell_found[CAPACITY-1])
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_prio_reg <= DEFAULT_PRIO_RESET;
            count_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                default_prio_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                count_reg <= count_next;
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // The head and count are read straight from the cells and the counter,
    // which hold the state after the item whose result is strobed.
    assign done          = done_reg;
    assign status        = status_reg;
    assign head_valid    = cell_entry[0].valid;
    assign head_tag      = cell_entry[0].valid ? cell_entry[0].tag : '0;
    assign head_priority = cell_entry[0].valid ? cell_entry[0].prio : '0;
    assign entry_count   = count_reg;

    // Every accepted item yields exactly one result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result strobed without an accepted item");

    // The counter and the chain agree on whether the list is empty or full.
    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == list_empty)
        else $error("entry count disagrees with head cell");

    a_count_full: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(CAPACITY)) == list_full)
        else $error("entry count disagrees with tail cell");

    // A refused grow leaves the list untouched.
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        accept && list_full && (req_type == REQ_PUSH_FRONT || req_type == REQ_INSERT)
        |=> (status == ST_FULL) && $stable(count_reg))
        else $error("grow on a full list was not refused");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Sorted priority list testbench
// Drives push-front, pop-front, insert and remove requests into the list and
// rewrites the default priority between phases. A behavioral copy of the list
// predicts every result, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import spl_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;

    // Kinds of entries in the stimulus plan. A settle step holds the sender
    // until the list has answered every item that was sent.
    typedef enum logic [1:0] {
        STEP_REQUEST,
        STEP_WRITE_DEFAULT,
        STEP_SETTLE,
        STEP_PACE
    } step_kind_t;

    typedef struct {
        step_kind_t               kind;
        logic [1:0]               req;
        logic [TAG_W-1:0]         tag;
        logic signed [PRIO_W-1:0] prio;
        int                       idle_pct;
    } plan_step_t;

    typedef struct {
        logic [1:0]               status;
        logic                     head_valid;
        logic [TAG_W-1:0]         head_tag;
        logic signed [PRIO_W-1:0] head_priority;
        logic [COUNT_W-1:0]       entry_count;
    } list_outcome_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_wr_en    = 1'b0;
    logic signed [PRIO_W-1:0]   cfg_wr_data  = '0;
    logic                       start        = 1'b0;
    logic [1:0]                 req_type     = REQ_PUSH_FRONT;
    logic [TAG_W-1:0]           name_tag     = '0;
    logic signed [PRIO_W-1:0]   priority_req = '0;
    logic                       busy;
    logic                       done;
    logic [1:0]                 status;
    logic                       head_valid;
    logic [TAG_W-1:0]           head_tag;
    logic signed [PRIO_W-1:0]   head_priority;
    logic [COUNT_W-1:0]         entry_count;

    // Stimulus plan, filled up front and consumed by the driver.
    plan_step_t    plan_q[$];
    // Results the list still owes, oldest first.
    list_outcome_t outcome_q[$];

    // Shadow copy of the list contents and of the default priority register.
    logic [TAG_W-1:0]         mirror_tag[CAPACITY];
    logic signed [PRIO_W-1:0] mirror_prio[CAPACITY];
    int                       held_count     = 0;
    logic signed [PRIO_W-1:0] mirror_default = DEFAULT_PRIO_RESET;

    int   sender_idle_pct = 0;
    int   settle_left     = 0;
    logic list_idle       = 1'b1;
    int   fault_count     = 0;
    int   cycle_count     = 0;

    sorted_priority_list #(
        .CAPACITY  (CAPACITY),
        .TAG_WIDTH (TAG_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .name_tag      (name_tag),
        .priority_req  (priority_req),
        .done          (done),
        .status        (status),
        .head_valid    (head_valid),
        .head_tag      (head_tag),
        .head_priority (head_priority),
        .entry_count   (entry_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // List prediction
    // ------------------------------------------------------------------------

    // Shift entries from pos onward one slot toward the tail and fill the gap.
    function automatic void open_slot(int pos, logic [TAG_W-1:0] tag,
                                      logic signed [PRIO_W-1:0] prio);
        for (int i = held_count; i > pos; i--)
        begin
            mirror_tag[i]  = mirror_tag[i - 1];
            mirror_prio[i] = mirror_prio[i - 1];
        end
        mirror_tag[pos]  = tag;
        mirror_prio[pos] = prio;
        held_count++;
    endfunction

    // Drop the entry at pos and pull the later entries one slot toward the head.
    function automatic void close_slot(int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            mirror_tag[i]  = mirror_tag[i + 1];
            mirror_prio[i] = mirror_prio[i + 1];
        end
        held_count--;
    endfunction

    // Applies one request to the shadow list and returns what the list reports.
    function automatic list_outcome_t apply_request(logic [1:0] req,
                                                    logic [TAG_W-1:0] tag,
                                                    logic signed [PRIO_W-1:0] prio);
        list_outcome_t            res;
        int                       pos;
        logic signed [PRIO_W-1:0] front_prio;
        res.status = ST_DONE;
        pos = 0;
        case (req)
            REQ_PUSH_FRONT:
            begin
                if (held_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    // One below the head, held at the most negative value.
                    if (held_count == 0)
                        front_prio = mirror_default;
                    else if (mirror_prio[0] == PRIO_MIN)
                        front_prio = PRIO_MIN;
                    else
                        front_prio = mirror_prio[0] - PRIO_W'(1);
                    open_slot(0, tag, front_prio);
                end
            end
            REQ_DROP_HEAD:
            begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else
                    close_slot(0);
            end
            REQ_INSERT:
            begin
                if (held_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    // A new entry lands ahead of the first equal priority.
                    while (pos < held_count && prio > mirror_prio[pos])
                        pos++;
                    open_slot(pos, tag, prio);
                end
            end
            default:
            begin
                while (pos < held_count && mirror_tag[pos] != tag)
                    pos++;
                if (pos < held_count)
                    close_slot(pos);
                else
                    res.status = ST_NOT_FOUND;
            end
        endcase
        res.head_valid    = (held_count > 0);
        res.head_tag      = (held_count > 0) ? mirror_tag[0] : '0;
        res.head_priority = (held_count > 0) ? mirror_prio[0] : '0;
        res.entry_count   = COUNT_W'(held_count);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    // Everything is decided on the rising edge. The values of start and
    // cfg_wr_en seen here are the ones that were on the ports during the cycle
    // that just ended, so an item is accepted exactly when start was high and
    // busy was low. The prediction for that item is queued right away; the
    // next value of each port is worked out in locals and assigned once.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic       next_start;
        logic       next_wr;
        plan_step_t step;
        if (!rst_n)
        begin
            start       <= 1'b0;
            cfg_wr_en   <= 1'b0;
            settle_left = 0;
        end
        else
        begin
            next_start = 1'b0;
            next_wr    = 1'b0;
            if (cfg_wr_en)
                mirror_default = cfg_wr_data;
            if (start && !busy)
                outcome_q.push_back(apply_request(req_type, name_tag, priority_req));

            if (start && busy)
                next_start = 1'b1;
            else if (settle_left > 0)
                settle_left--;
            else if (plan_q.size() != 0)
            begin
                step = plan_q[0];
                case (step.kind)
                    STEP_PACE:
                    begin
                        sender_idle_pct = step.idle_pct;
                        plan_q.delete(0);
                    end
                    STEP_SETTLE:
                    begin
                        // list_idle was sampled on the falling edge, after the
                        // checker had retired every result due by then. An item
                        // accepted on this very edge is caught by start.
                        if (list_idle && !start)
                        begin
                            settle_left = SETTLE_CYCLES;
                            plan_q.delete(0);
                        end
                    end
                    STEP_WRITE_DEFAULT:
                    begin
                        next_wr     = 1'b1;
                        cfg_wr_data <= step.prio;
                        plan_q.delete(0);
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= sender_idle_pct)
                        begin
                            next_start   = 1'b1;
                            req_type     <= step.req;
                            name_tag     <= step.tag;
                            priority_req <= step.prio;
                            plan_q.delete(0);
                        end
                    end
                endcase
            end
            start     <= next_start;
            cfg_wr_en <= next_wr;
        end
    end

    always @(negedge clk)
    begin
        list_idle <= (outcome_q.size() == 0);
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    // done marks a result for exactly one cycle; it is taken on the edge that
    // ends that cycle and compared with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        list_outcome_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with no item outstanding: status %0d count %0d",
                             $realtime, status, entry_count);
            end
            else
            begin
                want = outcome_q[0];
                outcome_q.delete(0);
                if (status !== want.status || head_valid !== want.head_valid ||
                    head_tag !== want.head_tag || head_priority !== want.head_priority ||
                    entry_count !== want.entry_count)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch: expected status %0d valid %0b tag %h prio %0d count %0d",
                                 $realtime, want.status, want.head_valid, want.head_tag,
                                 want.head_priority, want.entry_count);
                        $display("%0t:           got status %0d valid %0b tag %h prio %0d count %0d",
                                 $realtime, status, head_valid, head_tag, head_priority,
                                 entry_count);
                    end
                end
            end
        end
    end

    // A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------

    task automatic add_request(logic [1:0] req, logic [TAG_W-1:0] tag,
                               logic signed [PRIO_W-1:0] prio);
        plan_step_t step;
        step.kind     = STEP_REQUEST;
        step.req      = req;
        step.tag      = tag;
        step.prio     = prio;
        step.idle_pct = 0;
        plan_q.push_back(step);
    endtask

    task automatic add_control(step_kind_t kind, logic signed [PRIO_W-1:0] value,
                               int pct);
        plan_step_t step;
        step.kind     = kind;
        step.req      = REQ_PUSH_FRONT;
        step.tag      = '0;
        step.prio     = value;
        step.idle_pct = pct;
        plan_q.push_back(step);
    endtask

    // Tags come mostly from a small pool so that removes find their entry and
    // duplicates pile up; the rest are arbitrary.
    function automatic logic [TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return TAG_W'($urandom_range(0, 19));
        else if (r < 75)
            return '1;
        return TAG_W'($urandom);
    endfunction

    // Priorities cluster around ties, the extremes and the default value.
    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return PRIO_W'($urandom_range(0, 8) - 4);
        else if (r < 40)
        begin
            case ($urandom_range(3))
                0:       return PRIO_MIN;
                1:       return PRIO_MIN + PRIO_W'(1);
                2:       return {1'b0, {(PRIO_W-1){1'b1}}};
                default: return {1'b0, {(PRIO_W-2){1'b1}}, 1'b0};
            endcase
        end
        else if (r < 50)
            return PRIO_W'($urandom_range(990, 1010));
        return PRIO_W'($urandom);
    endfunction

    initial
    begin : stimulus
        logic signed [PRIO_W-1:0] default_choice[9];
        int                       grow_pct;
        int                       tide_left;
        logic [1:0]               req;

        // Directed opening: the empty-list answers, the reset default, the
        // saturating front push, ties on insert, a miss and a hit on remove,
        // then a fill up to capacity and both refusals of a full list.
        add_request(REQ_DROP_HEAD, '0, '0);
        add_request(REQ_REMOVE, '0, '0);
        add_request(REQ_PUSH_FRONT, '1, '1);
        add_request(REQ_INSERT, 16'h0001, {1'b0, {(PRIO_W-1){1'b1}}});
        add_request(REQ_INSERT, 16'h0002, PRIO_MIN);
        add_request(REQ_PUSH_FRONT, 16'hA5A5, '0);
        add_request(REQ_INSERT, 16'h5A5A, 16'sd1000);
        add_request(REQ_REMOVE, 16'h7777, '0);
        add_request(REQ_REMOVE, '1, '0);
        add_request(REQ_DROP_HEAD, '0, '0);
        for (int i = 0; i < 13; i++)
            add_request(REQ_INSERT, TAG_W'(16'h0100 + i), PRIO_W'($urandom));
        add_request(REQ_PUSH_FRONT, 16'h0BAD, '0);
        add_request(REQ_INSERT, 16'h0BAD, '0);

        // Random part in nine segments, each opened by a default priority
        // write while the list is quiet. The sender is moderately idle for
        // three segments, mostly idle for three, and never idle for the rest.
        default_choice = '{PRIO_MIN, {1'b0, {(PRIO_W-1){1'b1}}}, 16'sd0, -16'sd1,
                           16'sd1000, PRIO_W'($urandom), 16'sd1, PRIO_W'($urandom),
                           PRIO_MIN + PRIO_W'(1)};
        grow_pct  = 80;
        tide_left = 0;
        for (int seg = 0; seg < 9; seg++)
        begin
            if (seg % 3 == 0)
                add_control(STEP_PACE, '0, (seg == 0) ? 25 : (seg == 3) ? 66 : 0);
            add_control(STEP_SETTLE, '0, 0);
            add_control(STEP_WRITE_DEFAULT, default_choice[seg], 0);
            for (int n = 0; n < 92; n++)
            begin
                // Alternate growing and shrinking tides so the list keeps
                // reaching both full and empty.
                if (tide_left == 0)
                begin
                    tide_left = $urandom_range(8, 40);
                    case ($urandom_range(2))
                        0:       grow_pct = 85;
                        1:       grow_pct = 15;
                        default: grow_pct = 50;
                    endcase
                end
                tide_left--;
                if ($urandom_range(99) < grow_pct)
                    req = ($urandom_range(99) < 30) ? REQ_PUSH_FRONT : REQ_INSERT;
                else
                    req = ($urandom_range(99) < 40) ? REQ_DROP_HEAD : REQ_REMOVE;
                add_request(req, pick_tag(), pick_prio());
                if ($urandom_range(99) < 2)
                    add_control(STEP_SETTLE, '0, 0);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the plan to run out and every result to come back.
        while (plan_q.size() != 0 || start || outcome_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
